// ===== src/crd_pkg.sv =====
// ----------------------------------------------------------------------------
// crd_pkg
// Shared types and constants for the card reader reply deframer.
// ----------------------------------------------------------------------------
package crd_pkg;

  // reply bytes
  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] ACK_CODE   = 8'h30;
  localparam logic [7:0] FRAME_CODE = 8'h73;
  localparam logic [7:0] SEP2_CODE  = 8'h02;
  localparam logic [7:0] SEP3_CODE  = 8'h03;

  // input item kinds carried on tuser
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  // result kinds
  typedef enum logic [2:0] {
    KIND_ACK   = 3'd0,
    KIND_TRK   = 3'd1,
    KIND_EMPTY = 3'd2,
    KIND_BAD   = 3'd3,
    KIND_UNK   = 3'd4
  } kind_e;

  // command from parser to emitter
  typedef enum logic {
    CMD_SINGLE = 1'b0,
    CMD_DUMP   = 1'b1
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  // bit order reversal of one byte
  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

endpackage

// ===== src/crd_front.sv =====
// ----------------------------------------------------------------------------
// crd_front
// Reply parser: walks the frame layout one beat at a time, stores track-2
// bytes and issues commands for the emitter.
// ----------------------------------------------------------------------------
module crd_front import crd_pkg::*; #(
  parameter int MAX_TRACK_LEN = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_timeout_i,
  input  logic [7:0]                          in_byte_i,
  // command queue side
  input  logic                                q_full_i,
  output logic                                push_o,
  output cmd_t                                push_cmd_o,
  output logic [$clog2(MAX_TRACK_LEN+1)-1:0]  push_len_o,
  input  logic                                dump_done_i,
  // track-2 store write port
  output logic                                wr_en_o,
  output logic [((MAX_TRACK_LEN > 1) ? $clog2(MAX_TRACK_LEN) : 1)-1:0] wr_addr_o,
  output logic [7:0]                          wr_data_o
);

  localparam int LW = $clog2(MAX_TRACK_LEN + 1);
  localparam int AW = (MAX_TRACK_LEN > 1) ? $clog2(MAX_TRACK_LEN) : 1;
  localparam logic [7:0] MaxLenB = 8'(MAX_TRACK_LEN);

  typedef enum logic [15:0] {
    PH_HUNT  = 16'h0001,
    PH_CODE  = 16'h0002,
    PH_HDR1  = 16'h0004,
    PH_HDR2  = 16'h0008,
    PH_LEN1  = 16'h0010,
    PH_DAT1  = 16'h0020,
    PH_SEP1A = 16'h0040,
    PH_SEP1B = 16'h0080,
    PH_LEN2  = 16'h0100,
    PH_DAT2  = 16'h0200,
    PH_SEP2A = 16'h0400,
    PH_SEP2B = 16'h0800,
    PH_LEN3  = 16'h1000,
    PH_DAT3  = 16'h2000,
    PH_TAIL1 = 16'h4000,
    PH_TAIL2 = 16'h8000
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] len1_q, len1_d;
  logic [LW-1:0] len2_q, len2_d;
  logic [LW-1:0] len3_q, len3_d;
  logic [7:0]    prev_q, prev_d;
  logic          pend_q, pend_d;

  logic          acc;
  logic          bad;
  logic [LW-1:0] cnt_inc;
  logic [LW-1:0] b_len;

  // stall while a frame dump still reads the store or the command queue is full
  assign in_ready_o = !q_full_i && !pend_q;
  assign acc        = in_valid_i && in_ready_o;
  assign cnt_inc    = cnt_q + LW'(1);
  assign b_len      = in_byte_i[LW-1:0];

  assign wr_addr_o  = cnt_q[AW-1:0];
  assign wr_data_o  = in_byte_i;

  // phase walk
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    len1_d     = len1_q;
    len2_d     = len2_q;
    len3_d     = len3_q;
    prev_d     = prev_q;
    pend_d     = pend_q;
    bad        = 1'b0;
    push_o     = 1'b0;
    push_cmd_o = '{op: CMD_SINGLE, kind: KIND_ACK, data: 8'h00, last: 1'b0};
    push_len_o = len2_q;
    wr_en_o    = 1'b0;

    if (dump_done_i) begin
      pend_d = 1'b0;
    end

    if (acc) begin
      if (in_timeout_i == REQ_TIMEOUT) begin
        phase_d = PH_HUNT;
        cnt_d   = '0;
        prev_d  = 8'h00;
      end else begin
        prev_d = in_byte_i;
        unique case (phase_q)
          PH_HUNT: begin
            if (in_byte_i == ESC_BYTE) phase_d = PH_CODE;
          end
          PH_CODE: begin
            if (in_byte_i == ACK_CODE) begin
              push_o  = 1'b1;
              phase_d = PH_HUNT;
            end else if (in_byte_i == FRAME_CODE) begin
              phase_d = PH_HDR1;
            end else begin
              push_o          = 1'b1;
              push_cmd_o.kind = KIND_UNK;
              push_cmd_o.data = in_byte_i;
              phase_d         = PH_HUNT;
            end
          end
          PH_HDR1: phase_d = PH_HDR2;
          PH_HDR2: phase_d = PH_LEN1;
          PH_LEN1, PH_LEN2, PH_LEN3: begin
            if (in_byte_i > MaxLenB) begin
              push_o          = 1'b1;
              push_cmd_o.kind = KIND_BAD;
              phase_d         = PH_HUNT;
            end else begin
              cnt_d = '0;
              if (phase_q == PH_LEN1) begin
                len1_d  = b_len;
                phase_d = (in_byte_i == 8'h00) ? PH_SEP1A : PH_DAT1;
              end else if (phase_q == PH_LEN2) begin
                len2_d  = b_len;
                phase_d = (in_byte_i == 8'h00) ? PH_SEP2A : PH_DAT2;
              end else begin
                len3_d  = b_len;
                phase_d = (in_byte_i == 8'h00) ? PH_TAIL1 : PH_DAT3;
              end
            end
          end
          PH_DAT1: begin
            cnt_d = cnt_inc;
            if (cnt_inc >= len1_q) phase_d = PH_SEP1A;
          end
          PH_DAT2: begin
            wr_en_o = 1'b1;
            cnt_d   = cnt_inc;
            if (cnt_inc >= len2_q) phase_d = PH_SEP2A;
          end
          PH_DAT3: begin
            cnt_d = cnt_inc;
            if (cnt_inc >= len3_q) phase_d = PH_TAIL1;
          end
          PH_SEP1A: begin
            if (in_byte_i == ESC_BYTE) begin
              phase_d = PH_SEP1B;
            end else if (in_byte_i == SEP2_CODE && prev_q == ESC_BYTE && len1_q != '0) begin
              // separator came one byte early, last data byte was its escape
              len1_d  = len1_q - LW'(1);
              phase_d = PH_LEN2;
            end else begin
              bad     = 1'b1;
              phase_d = PH_HUNT;
            end
          end
          PH_SEP2A: begin
            if (in_byte_i == ESC_BYTE) begin
              phase_d = PH_SEP2B;
            end else if (in_byte_i == SEP3_CODE && prev_q == ESC_BYTE && len2_q != '0) begin
              len2_d  = len2_q - LW'(1);
              phase_d = PH_LEN3;
            end else begin
              bad     = 1'b1;
              phase_d = PH_HUNT;
            end
          end
          PH_SEP1B: begin
            if (in_byte_i == SEP2_CODE) begin
              phase_d = PH_LEN2;
            end else begin
              bad     = 1'b1;
              phase_d = PH_HUNT;
            end
          end
          PH_SEP2B: begin
            if (in_byte_i == SEP3_CODE) begin
              phase_d = PH_LEN3;
            end else begin
              bad     = 1'b1;
              phase_d = PH_HUNT;
            end
          end
          PH_TAIL1: phase_d = PH_TAIL2;
          PH_TAIL2: begin
            push_o = 1'b1;
            if (len2_q == '0) begin
              push_cmd_o.kind = KIND_EMPTY;
              push_cmd_o.last = 1'b1;
            end else begin
              push_cmd_o.op   = CMD_DUMP;
              push_cmd_o.kind = KIND_TRK;
              pend_d          = 1'b1;
            end
            phase_d = PH_HUNT;
          end
          default: phase_d = PH_HUNT;
        endcase
        if (bad) begin
          push_o          = 1'b1;
          push_cmd_o.kind = KIND_BAD;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      len1_q  <= '0;
      len2_q  <= '0;
      len3_q  <= '0;
      prev_q  <= 8'h00;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len1_q  <= len1_d;
      len2_q  <= len2_d;
      len3_q  <= len3_d;
      prev_q  <= prev_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// ===== src/crd_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// crd_cmd_fifo
// Two-entry command queue between parser and emitter.
// ----------------------------------------------------------------------------
module crd_cmd_fifo import crd_pkg::*; #(
  parameter int LW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmd_t          push_cmd_i,
  input  logic [LW-1:0] push_len_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output cmd_t          pop_cmd_o,
  output logic [LW-1:0] pop_len_o
);

  cmd_t          cmd_q [2];
  logic [LW-1:0] len_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign pop_cmd_o = cmd_q[rd_ptr_q];
  assign pop_len_o = len_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      cmd_q[wr_ptr_q] <= push_cmd_i;
      len_q[wr_ptr_q] <= push_len_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("command popped from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue fill count out of range");

endmodule

// ===== src/crd_back.sv =====
// ----------------------------------------------------------------------------
// crd_back
// Result emitter: holds the track-2 store, turns commands into result beats
// and drives the output register.
// ----------------------------------------------------------------------------
module crd_back import crd_pkg::*; #(
  parameter int MAX_TRACK_LEN = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command queue side
  input  logic                                q_empty_i,
  output logic                                pop_o,
  input  cmd_t                                pop_cmd_i,
  input  logic [$clog2(MAX_TRACK_LEN+1)-1:0]  pop_len_i,
  output logic                                dump_done_o,
  // track-2 store write port
  input  logic                                wr_en_i,
  input  logic [((MAX_TRACK_LEN > 1) ? $clog2(MAX_TRACK_LEN) : 1)-1:0] wr_addr_i,
  input  logic [7:0]                          wr_data_i,
  // result stream
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output kind_e                               out_kind_o,
  output logic [7:0]                          out_data_o,
  output logic                                out_last_o
);

  localparam int LW = $clog2(MAX_TRACK_LEN + 1);
  localparam int AW = (MAX_TRACK_LEN > 1) ? $clog2(MAX_TRACK_LEN) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  logic [7:0]    mem [MAX_TRACK_LEN];
  logic [7:0]    rd_q;

  state_e        state_q, state_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] len_q, len_d;
  logic          ov_q, ov_d;
  kind_e         okind_q, okind_d;
  logic [7:0]    odata_q, odata_d;
  logic          olast_q, olast_d;
  logic          out_free;
  logic          is_last;

  assign out_free    = !ov_q || out_ready_i;
  assign is_last     = (idx_q == len_q - LW'(1));
  assign out_valid_o = ov_q;
  assign out_kind_o  = okind_q;
  assign out_data_o  = odata_q;
  assign out_last_o  = olast_q;

  // track-2 store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_q <= mem[idx_q[AW-1:0]];
  end

  // command sequencing
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    len_d       = len_q;
    ov_d        = ov_q && !out_ready_i;
    okind_d     = okind_q;
    odata_d     = odata_q;
    olast_d     = olast_q;
    pop_o       = 1'b0;
    dump_done_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i && out_free) begin
          pop_o = 1'b1;
          if (pop_cmd_i.op == CMD_DUMP) begin
            idx_d   = '0;
            len_d   = pop_len_i;
            state_d = ST_READ;
          end else begin
            ov_d    = 1'b1;
            okind_d = pop_cmd_i.kind;
            odata_d = pop_cmd_i.data;
            olast_d = pop_cmd_i.last;
          end
        end
      end
      ST_READ: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = KIND_TRK;
          odata_d = rev8(rd_q);
          olast_d = is_last;
          if (is_last) begin
            dump_done_o = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            idx_d   = idx_q + LW'(1);
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output payload
  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
    len_q   <= len_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (idx_q < len_q))
    else $error("dump index past track length");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dump_done_o |=> (state_q == ST_IDLE))
    else $error("emitter not idle after dump");

  a_no_pop_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE))
    else $error("command popped during dump");

endmodule

// ===== src/card_reader_response_deframer_core.sv =====
// ----------------------------------------------------------------------------
// card_reader_response_deframer_core
// Card reader reply deframer: parser front, command queue, emitter back.
// ----------------------------------------------------------------------------
// result path: a result passes through the command queue and then the m_axis output
//   register; track-2 bytes also pass the registered store read first
// throughput: one input beat per cycle; input stalls while a frame dump is
//   pending or the two-entry command queue is full
// frame dump: each track-2 byte is read in ST_READ, then emitted in ST_EMIT, before the next is read
// reset: rst_ni async active low clears parser, queue and emitter control;
//   the track-2 store is not cleared and is always written before it is read
module card_reader_response_deframer_core import crd_pkg::*; #(
  parameter int MAX_TRACK_LEN = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0] s_axis_tuser,   // [0] req_type
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data
  output logic [2:0] m_axis_tuser,   // [2:0] kind
  output logic       m_axis_tlast    // last
);

  localparam int LW = $clog2(MAX_TRACK_LEN + 1);
  localparam int AW = (MAX_TRACK_LEN > 1) ? $clog2(MAX_TRACK_LEN) : 1;

  logic          q_full, q_empty;
  logic          push, pop;
  cmd_t          push_cmd, pop_cmd;
  logic [LW-1:0] push_len, pop_len;
  logic          dump_done;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  kind_e         out_kind;

  // parser
  crd_front #(.MAX_TRACK_LEN(MAX_TRACK_LEN)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_timeout_i(s_axis_tuser[0]),
    .in_byte_i   (s_axis_tdata),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .push_len_o  (push_len),
    .dump_done_i (dump_done),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // command queue
  crd_cmd_fifo #(.LW(LW)) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .push_len_i(push_len),
    .full_o    (q_full),
    .pop_i     (pop),
    .empty_o   (q_empty),
    .pop_cmd_o (pop_cmd),
    .pop_len_o (pop_len)
  );

  // emitter
  crd_back #(.MAX_TRACK_LEN(MAX_TRACK_LEN)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .pop_o      (pop),
    .pop_cmd_i  (pop_cmd),
    .pop_len_i  (pop_len),
    .dump_done_o(dump_done),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_kind_o (out_kind),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;

endmodule

// ===== sim/crd_reply_checker.sv =====
// ----------------------------------------------------------------------------
// crd_reply_checker
// Watches both streams of the card reader reply deframer. Every accepted
// input beat runs through a cycle-free model of the frame parser, which
// queues the replies it expects. Every accepted output beat is compared
// field by field with the oldest queued reply.
// ----------------------------------------------------------------------------
module crd_reply_checker import crd_pkg::*; #(
  parameter int MAX_TRACK_LEN = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0] s_axis_tuser,   // [0] req_type
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] data
  input  logic [2:0] m_axis_tuser,   // [2:0] kind
  input  logic       m_axis_tlast,   // last
  output int         fail_count_o,
  output int         pending_o
);

  // parser position inside a reply
  typedef enum logic [3:0] {
    ST_HUNT, ST_CODE, ST_HDR1, ST_HDR2,
    ST_LEN1, ST_DAT1, ST_SEP1A, ST_SEP1B,
    ST_LEN2, ST_DAT2, ST_SEP2A, ST_SEP2B,
    ST_LEN3, ST_DAT3, ST_TAIL1, ST_TAIL2
  } frame_state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } reply_t;

  reply_t       expected_replies[$];
  reply_t       want;
  frame_state_e st;
  logic [4:0]   byte_cnt;
  logic [4:0]   trk1_len;
  logic [4:0]   trk2_len;
  logic [4:0]   trk3_len;
  logic [7:0]   prev_byte;
  logic [7:0]   trk2_mem [MAX_TRACK_LEN];

  function automatic logic [7:0] mirror_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

  task automatic push_reply(input kind_e k, input logic [7:0] d, input logic l);
    expected_replies.push_back('{k, d, l});
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch: %s got 0x%0h, expected 0x%0h", what, got, exp_val);
    fail_count_o++;
  endtask

  // advance the parser by one input beat and queue the replies it causes
  task automatic predict_replies(input logic req, input logic [7:0] b);
    logic bad;
    bad = 1'b0;
    if (req == REQ_TIMEOUT) begin
      st        = ST_HUNT;
      byte_cnt  = '0;
      prev_byte = '0;
      return;
    end
    case (st)
      ST_HUNT: begin
        if (b == ESC_BYTE) st = ST_CODE;
      end
      ST_CODE: begin
        if (b == ACK_CODE) begin
          push_reply(KIND_ACK, 8'h00, 1'b0);
          st = ST_HUNT;
        end else if (b == FRAME_CODE) begin
          st = ST_HDR1;
        end else begin
          push_reply(KIND_UNK, b, 1'b0);
          st = ST_HUNT;
        end
      end
      ST_HDR1: st = ST_HDR2;
      ST_HDR2: st = ST_LEN1;
      ST_LEN1, ST_LEN2, ST_LEN3: begin
        if (b > MAX_TRACK_LEN) begin
          push_reply(KIND_BAD, 8'h00, 1'b0);
          st = ST_HUNT;
        end else begin
          byte_cnt = '0;
          if (st == ST_LEN1) begin
            trk1_len = b[4:0];
            st = (b == 8'd0) ? ST_SEP1A : ST_DAT1;
          end else if (st == ST_LEN2) begin
            trk2_len = b[4:0];
            st = (b == 8'd0) ? ST_SEP2A : ST_DAT2;
          end else begin
            trk3_len = b[4:0];
            st = (b == 8'd0) ? ST_TAIL1 : ST_DAT3;
          end
        end
      end
      ST_DAT1: begin
        byte_cnt++;
        if (byte_cnt >= trk1_len) st = ST_SEP1A;
      end
      ST_DAT2: begin
        if (byte_cnt < MAX_TRACK_LEN) trk2_mem[byte_cnt] = b;
        byte_cnt++;
        if (byte_cnt >= trk2_len) st = ST_SEP2A;
      end
      ST_DAT3: begin
        byte_cnt++;
        if (byte_cnt >= trk3_len) st = ST_TAIL1;
      end
      // separator one byte early: the last data byte was the escape
      ST_SEP1A: begin
        if (b == ESC_BYTE) begin
          st = ST_SEP1B;
        end else if (b == SEP2_CODE && prev_byte == ESC_BYTE && trk1_len != 0) begin
          trk1_len--;
          st = ST_LEN2;
        end else begin
          bad = 1'b1;
          st  = ST_HUNT;
        end
      end
      ST_SEP2A: begin
        if (b == ESC_BYTE) begin
          st = ST_SEP2B;
        end else if (b == SEP3_CODE && prev_byte == ESC_BYTE && trk2_len != 0) begin
          trk2_len--;
          st = ST_LEN3;
        end else begin
          bad = 1'b1;
          st  = ST_HUNT;
        end
      end
      ST_SEP1B: begin
        if (b == SEP2_CODE) begin
          st = ST_LEN2;
        end else begin
          bad = 1'b1;
          st  = ST_HUNT;
        end
      end
      ST_SEP2B: begin
        if (b == SEP3_CODE) begin
          st = ST_LEN3;
        end else begin
          bad = 1'b1;
          st  = ST_HUNT;
        end
      end
      ST_TAIL1: st = ST_TAIL2;
      // frame complete: dump track 2 bit-reversed, or report an empty track 2
      ST_TAIL2: begin
        if (trk2_len == 0) begin
          push_reply(KIND_EMPTY, 8'h00, 1'b1);
        end else begin
          for (int i = 0; i < trk2_len; i++) begin
            push_reply(KIND_TRK, mirror_byte(trk2_mem[i]), (i + 1 == trk2_len));
          end
        end
        st = ST_HUNT;
      end
      default: st = ST_HUNT;
    endcase
    if (bad) push_reply(KIND_BAD, 8'h00, 1'b0);
    prev_byte = b;
  endtask

  // compare output beats first, then predict from the input beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st           = ST_HUNT;
      byte_cnt     = '0;
      trk1_len     = '0;
      trk2_len     = '0;
      trk3_len     = '0;
      prev_byte    = '0;
      fail_count_o = 0;
      pending_o    = 0;
      expected_replies.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply beat, kind", m_axis_tuser, 0);
        end else begin
          want = expected_replies.pop_front();
          if (m_axis_tuser != want.kind) report_mismatch("kind", m_axis_tuser, want.kind);
          if (m_axis_tdata != want.data) report_mismatch("data", m_axis_tdata, want.data);
          if (m_axis_tlast != want.last) report_mismatch("last", m_axis_tlast, want.last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_replies(s_axis_tuser[0], s_axis_tdata);
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the card reader reply deframer. Sends a short
// directed set of replies, then random frames, acks, unknown codes, noise
// and timeouts under three idling mixes, with one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import crd_pkg::*;

  localparam int MAX_TRACK_LEN = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 15;

  // ways a random frame can go wrong
  typedef enum int {
    FAULT_NONE,
    FAULT_EARLY_SEP,
    FAULT_BAD_SEP,
    FAULT_LONG_TRACK,
    FAULT_TIMEOUT
  } frame_fault_e;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int beats_sent;
  int hold_req;
  int hold_ack;
  int hold_left;
  int cycles;

  card_reader_response_deframer_core #(
    .MAX_TRACK_LEN (MAX_TRACK_LEN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  crd_reply_checker #(
    .MAX_TRACK_LEN (MAX_TRACK_LEN)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL card_reader_response_deframer_core");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_ack      = 0;
    hold_left     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one beat, with random idle cycles first; entered and left at negedge
  task automatic put_beat(input logic req, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_byte(input logic [7:0] b);
    put_beat(REQ_BYTE, b);
  endtask

  // sender pause until every expected reply has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // track data leans on the escape byte to provoke separator cases
  function automatic logic [7:0] track_byte();
    return ($urandom_range(3) == 0) ? ESC_BYTE : 8'($urandom_range(255));
  endfunction

  // one three-track frame, clean or with one fault; trk2_force >= 0 fixes track 2
  task automatic send_frame(input int trk2_force);
    int           lens[3];
    int           fault_trk;
    int           r;
    bit           early;
    frame_fault_e fault;
    for (int j = 0; j < 3; j++) begin
      lens[j] = ($urandom_range(9) == 0) ? MAX_TRACK_LEN : $urandom_range(5);
    end
    r = $urandom_range(99);
    if (r < 60)      fault = FAULT_NONE;
    else if (r < 74) fault = FAULT_EARLY_SEP;
    else if (r < 84) fault = FAULT_BAD_SEP;
    else if (r < 92) fault = FAULT_LONG_TRACK;
    else             fault = FAULT_TIMEOUT;
    fault_trk = $urandom_range(2);
    if (fault == FAULT_EARLY_SEP || fault == FAULT_BAD_SEP) begin
      fault_trk = $urandom_range(1);
      if (lens[fault_trk] == 0) lens[fault_trk] = $urandom_range(1, MAX_TRACK_LEN);
    end
    if (trk2_force >= 0) begin
      lens[1] = trk2_force;
      fault   = FAULT_NONE;
    end

    put_byte(ESC_BYTE);
    put_byte(FRAME_CODE);
    put_byte(8'($urandom_range(255)));
    put_byte(8'($urandom_range(255)));
    for (int j = 0; j < 3; j++) begin
      if (fault_trk == j && fault == FAULT_LONG_TRACK) begin
        put_byte(8'($urandom_range(MAX_TRACK_LEN + 1, 255)));
        return;
      end
      if (fault_trk == j && fault == FAULT_TIMEOUT) begin
        put_beat(REQ_TIMEOUT, 8'($urandom_range(255)));
        return;
      end
      early = (fault_trk == j && fault == FAULT_EARLY_SEP);
      put_byte(8'(lens[j]));
      for (int i = 0; i < lens[j] - (early ? 1 : 0); i++) begin
        put_byte(track_byte());
      end
      if (j < 2) begin
        if (fault_trk == j && fault == FAULT_BAD_SEP) begin
          if ($urandom_range(1) == 0) put_byte(ESC_BYTE);
          put_byte(8'($urandom_range(255)));
          return;
        end
        put_byte(ESC_BYTE);
        put_byte((j == 0) ? SEP2_CODE : SEP3_CODE);
      end
    end
    put_byte(8'($urandom_range(255)));
    put_byte(8'($urandom_range(255)));
  endtask

  // random mix of replies until the beat budget is used up
  task automatic run_random(input int budget);
    int r;
    int start;
    start = beats_sent;
    while (beats_sent - start < budget) begin
      r = $urandom_range(99);
      if (r < 60) begin
        send_frame(-1);
      end else if (r < 70) begin
        put_byte(ESC_BYTE);
        put_byte(ACK_CODE);
      end else if (r < 78) begin
        put_byte(ESC_BYTE);
        put_byte(8'($urandom_range(255)));
      end else if (r < 90) begin
        repeat ($urandom_range(1, 3)) begin
          put_byte(8'($urandom_range(255)));
        end
      end else begin
        put_beat(REQ_TIMEOUT, 8'($urandom_range(255)));
      end
    end
  endtask

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_BYTE;
    send_idle_pct = 13;
    recv_idle_pct = 72;
    beats_sent    = 0;
    hold_req      = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: ack, unknown codes, noise, timeout, long track, empty frame
    put_byte(ESC_BYTE);
    put_byte(ACK_CODE);
    put_byte(ESC_BYTE);
    put_byte(ESC_BYTE);
    put_byte(ESC_BYTE);
    put_byte(8'hff);
    put_byte(8'h00);
    put_beat(REQ_TIMEOUT, 8'hff);
    put_byte(ESC_BYTE);
    put_byte(FRAME_CODE);
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(8'd21);
    put_byte(ESC_BYTE);
    put_byte(FRAME_CODE);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(8'd0);
    put_byte(ESC_BYTE);
    put_byte(SEP2_CODE);
    put_byte(8'd0);
    put_byte(ESC_BYTE);
    put_byte(SEP3_CODE);
    put_byte(8'd0);
    put_byte(8'hff);
    put_byte(8'hff);

    run_random(RANDOM_ITEMS);
    wait_drained();

    send_idle_pct = 72;
    recv_idle_pct = 13;
    run_random(RANDOM_ITEMS);
    wait_drained();

    // no idling; a full track 2 frame under a long output hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    send_frame(MAX_TRACK_LEN);
    run_random(RANDOM_ITEMS);
    wait_drained();
    repeat (32) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("PASS card_reader_response_deframer_core");
    end else begin
      $display("FAIL card_reader_response_deframer_core");
    end
    $finish;
  end

endmodule
